// ===== design/cte_pkg.sv =====
package cte_pkg;

   // default sizes
   localparam int TABLE_ENTRIES_DEF   = 256;
   localparam int MAX_CODE_LENGTH_DEF = 32;

   // fixed field widths
   localparam int KIND_W   = 2;
   localparam int INDEX_W  = 8;
   localparam int SYMBOL_W = 8;
   localparam int CODE_W   = 32;
   localparam int LENGTH_W = 6;
   localparam int COUNT_W  = 9;

   // request kinds
   localparam logic [KIND_W-1:0] KIND_LOAD   = 2'd0;
   localparam logic [KIND_W-1:0] KIND_ENCODE = 2'd1;
   localparam logic [KIND_W-1:0] KIND_DECODE = 2'd2;

   // response kinds
   localparam logic [KIND_W-1:0] RES_CODE     = 2'd0;
   localparam logic [KIND_W-1:0] RES_SYMBOL   = 2'd1;
   localparam logic [KIND_W-1:0] RES_OVERFLOW = 2'd2;

   // one code table entry
   typedef struct packed {
      logic [SYMBOL_W-1:0] sym;
      logic [CODE_W-1:0]   bits;
      logic [LENGTH_W-1:0] len;
   } entry_type;

endpackage

// ===== design/cte_table_ram.sv =====
module cte_table_ram #(
   parameter int DEPTH = cte_pkg::TABLE_ENTRIES_DEF
) (
   input  logic                             clock,
   input  logic                             wr_en,
   input  logic [$clog2(DEPTH)-1:0]         wr_addr,
   input  cte_pkg::entry_type               wr_data,
   input  logic                             rd_en,
   input  logic [$clog2(DEPTH)-1:0]         rd_addr,
   output cte_pkg::entry_type               rd_data
);

   cte_pkg::entry_type mem [DEPTH];
   cte_pkg::entry_type rd_data_ff;

   // single write port, single registered read port
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// ===== design/cte_seq.sv =====
module cte_seq #(
   parameter int TABLE_ENTRIES   = cte_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_CODE_LENGTH = cte_pkg::MAX_CODE_LENGTH_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [cte_pkg::KIND_W-1:0]          req_kind,
   input  logic [cte_pkg::INDEX_W-1:0]         req_entry_index,
   input  logic [cte_pkg::SYMBOL_W-1:0]        req_symbol,
   input  logic [cte_pkg::CODE_W-1:0]          req_code_bits,
   input  logic [cte_pkg::LENGTH_W-1:0]        req_code_length,
   input  logic                                req_data_bit,
   input  logic [cte_pkg::COUNT_W-1:0]         search_count,
   output logic                                mem_wr_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0]    mem_wr_addr,
   output cte_pkg::entry_type                  mem_wr_data,
   output logic                                mem_rd_en,
   output logic [$clog2(TABLE_ENTRIES)-1:0]    mem_rd_addr,
   input  cte_pkg::entry_type                  mem_rd_data,
   output logic                                rsp_strobe,
   output logic [cte_pkg::KIND_W-1:0]          rsp_result_kind,
   output logic [cte_pkg::CODE_W-1:0]          rsp_code_out,
   output logic [cte_pkg::LENGTH_W-1:0]        rsp_code_out_length,
   output logic [cte_pkg::SYMBOL_W-1:0]        rsp_symbol_out
);

   localparam int ADDR_W = $clog2(TABLE_ENTRIES);
   localparam int LEN_W  = $clog2(MAX_CODE_LENGTH + 1);
   localparam int CMP_W  = (MAX_CODE_LENGTH > cte_pkg::CODE_W) ? MAX_CODE_LENGTH
                                                                : cte_pkg::CODE_W;
   localparam int LCMP_W = (LEN_W > cte_pkg::LENGTH_W) ? LEN_W : cte_pkg::LENGTH_W;

   typedef enum logic {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type                        state_ff;
   logic                             decode_ff;
   logic [cte_pkg::SYMBOL_W-1:0]     sym_ff;
   logic [cte_pkg::COUNT_W-1:0]      issue_ff;
   logic                             pend_ff;
   logic [MAX_CODE_LENGTH-1:0]       acc_ff;
   logic [MAX_CODE_LENGTH-1:0]       acc_in;
   logic [LEN_W-1:0]                 acc_len_ff;
   logic [LEN_W-1:0]                 acc_len_in;
   logic                             strobe_ff;
   logic [cte_pkg::KIND_W-1:0]       kind_ff;
   logic [cte_pkg::CODE_W-1:0]       code_ff;
   logic [cte_pkg::LENGTH_W-1:0]     code_len_ff;
   logic [cte_pkg::SYMBOL_W-1:0]     sym_out_ff;

   logic                             accept;
   logic                             enc_hit;
   logic                             dec_hit;
   logic                             hit;
   logic                             more;
   logic [cte_pkg::CODE_W-1:0]       load_mask;

   assign busy   = (state_ff != ST_IDLE);
   assign accept = start && !busy;

   // load path: write straight into the table on the accept edge
   always_comb begin
      if (req_code_length >= cte_pkg::LENGTH_W'(cte_pkg::CODE_W)) begin
         load_mask = '1;
      end else begin
         load_mask = ~({cte_pkg::CODE_W{1'b1}} << req_code_length);
      end
   end

   assign mem_wr_en = accept && (req_kind == cte_pkg::KIND_LOAD) &&
                      ({1'b0, req_entry_index} < (cte_pkg::INDEX_W + 1)'(TABLE_ENTRIES));
   assign mem_wr_addr      = ADDR_W'(req_entry_index);
   assign mem_wr_data.sym  = req_symbol;
   assign mem_wr_data.bits = req_code_bits & load_mask;
   assign mem_wr_data.len  = req_code_length;

   // accumulator update for a decode transaction
   assign acc_in     = {acc_ff[MAX_CODE_LENGTH-2:0], req_data_bit};
   assign acc_len_in = acc_len_ff + LEN_W'(1);

   // compare the entry read last cycle
   assign enc_hit = (mem_rd_data.sym == sym_ff);
   assign dec_hit = (LCMP_W'(mem_rd_data.len) == LCMP_W'(acc_len_ff)) &&
                    (CMP_W'(mem_rd_data.bits) == CMP_W'(acc_ff));
   assign hit     = pend_ff && (decode_ff ? dec_hit : enc_hit);
   assign more    = (issue_ff < search_count);

   assign mem_rd_en   = (state_ff == ST_SCAN) && !hit && more;
   assign mem_rd_addr = issue_ff[ADDR_W-1:0];

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_IDLE;
         pend_ff    <= 1'b0;
         acc_ff     <= '0;
         acc_len_ff <= '0;
         strobe_ff  <= 1'b0;
      end else begin
         strobe_ff <= 1'b0;
         unique case (state_ff)
            ST_IDLE: begin
               if (start) begin
                  issue_ff <= '0;
                  pend_ff  <= 1'b0;
                  sym_ff   <= req_symbol;
                  case (req_kind)
                     cte_pkg::KIND_ENCODE: begin
                        decode_ff <= 1'b0;
                        state_ff  <= ST_SCAN;
                     end
                     cte_pkg::KIND_DECODE: begin
                        decode_ff  <= 1'b1;
                        acc_ff     <= acc_in;
                        acc_len_ff <= acc_len_in;
                        state_ff   <= ST_SCAN;
                     end
                     default: ;
                  endcase
               end
            end
            ST_SCAN: begin
               if (hit) begin
                  strobe_ff <= 1'b1;
                  pend_ff   <= 1'b0;
                  state_ff  <= ST_IDLE;
                  if (decode_ff) begin
                     kind_ff     <= cte_pkg::RES_SYMBOL;
                     code_ff     <= '0;
                     code_len_ff <= '0;
                     sym_out_ff  <= mem_rd_data.sym;
                     acc_ff      <= '0;
                     acc_len_ff  <= '0;
                  end else begin
                     kind_ff     <= cte_pkg::RES_CODE;
                     code_ff     <= mem_rd_data.bits;
                     code_len_ff <= mem_rd_data.len;
                     sym_out_ff  <= '0;
                  end
               end else if (more) begin
                  issue_ff <= issue_ff + cte_pkg::COUNT_W'(1);
                  pend_ff  <= 1'b1;
               end else begin
                  pend_ff  <= 1'b0;
                  state_ff <= ST_IDLE;
                  // no match anywhere: a full accumulator is an overflow
                  if (decode_ff && (acc_len_ff >= LEN_W'(MAX_CODE_LENGTH))) begin
                     strobe_ff   <= 1'b1;
                     kind_ff     <= cte_pkg::RES_OVERFLOW;
                     code_ff     <= '0;
                     code_len_ff <= '0;
                     sym_out_ff  <= '0;
                     acc_ff      <= '0;
                     acc_len_ff  <= '0;
                  end
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_strobe          = strobe_ff;
   assign rsp_result_kind     = kind_ff;
   assign rsp_code_out        = code_ff;
   assign rsp_code_out_length = code_len_ff;
   assign rsp_symbol_out      = sym_out_ff;

endmodule

// ===== design/code_table_encode_decode.sv =====
// Prefix code table encoder/decoder. Load transactions (busy stays low, no
// response) write one table entry: symbol, code bits masked to the code
// length, and length. Encode transactions return the code of the
// lowest-index entry holding the symbol; decode transactions shift one bit
// into the accumulator and return the symbol of the lowest-index entry whose
// code and length equal it, or an overflow once MAX_CODE_LENGTH bits gather
// unmatched. Only the first csr_wdata entries (capped at TABLE_ENTRIES) are
// searched. The table sits in one single-port-read RAM scanned one entry per
// cycle, so an encode or decode transaction holds busy while it reads entries
// up to the first match, or all searched entries if none match; any response
// strobe rises in the same cycle that busy drops. rsp_strobe is high for
// exactly one cycle per response and the receiver cannot stall it: it must
// take every response the cycle it appears. Write csr only while idle.
module code_table_encode_decode #(
   parameter int TABLE_ENTRIES   = cte_pkg::TABLE_ENTRIES_DEF,
   parameter int MAX_CODE_LENGTH = cte_pkg::MAX_CODE_LENGTH_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              start,
   output logic                              busy,
   input  logic [cte_pkg::KIND_W-1:0]        req_kind,
   input  logic [cte_pkg::INDEX_W-1:0]       req_entry_index,
   input  logic [cte_pkg::SYMBOL_W-1:0]      req_symbol,
   input  logic [cte_pkg::CODE_W-1:0]        req_code_bits,
   input  logic [cte_pkg::LENGTH_W-1:0]      req_code_length,
   input  logic                              req_data_bit,
   // response channel
   output logic                              rsp_strobe,
   output logic [cte_pkg::KIND_W-1:0]        rsp_result_kind,
   output logic [cte_pkg::CODE_W-1:0]        rsp_code_out,
   output logic [cte_pkg::LENGTH_W-1:0]      rsp_code_out_length,
   output logic [cte_pkg::SYMBOL_W-1:0]      rsp_symbol_out,
   // entry count register
   input  logic                              csr_we,
   input  logic [cte_pkg::COUNT_W-1:0]       csr_wdata
);

   localparam int ADDR_W = $clog2(TABLE_ENTRIES);

   logic [cte_pkg::COUNT_W-1:0] entry_count_ff;
   logic [cte_pkg::COUNT_W-1:0] search_count;

   logic                        mem_wr_en;
   logic [ADDR_W-1:0]           mem_wr_addr;
   cte_pkg::entry_type          mem_wr_data;
   logic                        mem_rd_en;
   logic [ADDR_W-1:0]           mem_rd_addr;
   cte_pkg::entry_type          mem_rd_data;

   // entry count register, no read-back
   always_ff @(posedge clock) begin
      if (reset) begin
         entry_count_ff <= '0;
      end else if (csr_we) begin
         entry_count_ff <= csr_wdata;
      end
   end

   // counts beyond the table size search the whole table
   assign search_count = (entry_count_ff > cte_pkg::COUNT_W'(TABLE_ENTRIES)) ?
                         cte_pkg::COUNT_W'(TABLE_ENTRIES) : entry_count_ff;

   cte_table_ram #(
      .DEPTH (TABLE_ENTRIES)
   ) u_table (
      .clock   (clock),
      .wr_en   (mem_wr_en),
      .wr_addr (mem_wr_addr),
      .wr_data (mem_wr_data),
      .rd_en   (mem_rd_en),
      .rd_addr (mem_rd_addr),
      .rd_data (mem_rd_data)
   );

   // sequencer: scan, compare, accumulator and response registers
   cte_seq #(
      .TABLE_ENTRIES   (TABLE_ENTRIES),
      .MAX_CODE_LENGTH (MAX_CODE_LENGTH)
   ) u_seq (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_entry_index     (req_entry_index),
      .req_symbol          (req_symbol),
      .req_code_bits       (req_code_bits),
      .req_code_length     (req_code_length),
      .req_data_bit        (req_data_bit),
      .search_count        (search_count),
      .mem_wr_en           (mem_wr_en),
      .mem_wr_addr         (mem_wr_addr),
      .mem_wr_data         (mem_wr_data),
      .mem_rd_en           (mem_rd_en),
      .mem_rd_addr         (mem_rd_addr),
      .mem_rd_data         (mem_rd_data),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_code_out        (rsp_code_out),
      .rsp_code_out_length (rsp_code_out_length),
      .rsp_symbol_out      (rsp_symbol_out)
   );

endmodule

// ===== tb/sv/code_table_encode_decode_tb.sv =====
module code_table_encode_decode_tb;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRIES      = cte_pkg::TABLE_ENTRIES_DEF;
   localparam int MAX_LEN      = cte_pkg::MAX_CODE_LENGTH_DEF;
   // a silent encode or decode may still be scanning when the last response
   // shows up; it outlasts a full table scan and so covers any work left
   localparam int DRAIN_CYCLES = ENTRIES + 8;
   localparam int WAIT_LIMIT   = 4 * ENTRIES + 64;
   localparam int PHASES       = 11;
   localparam int PRINT_LIMIT  = 100;

   // kind 3 has no meaning to the block and must be dropped silently
   localparam logic [cte_pkg::KIND_W-1:0] KIND_UNUSED = 2'd3;

   typedef struct packed {
      logic [cte_pkg::KIND_W-1:0]   kind;
      logic [cte_pkg::INDEX_W-1:0]  index;
      logic [cte_pkg::SYMBOL_W-1:0] symbol;
      logic [cte_pkg::CODE_W-1:0]   bits;
      logic [cte_pkg::LENGTH_W-1:0] length;
      logic                         data_bit;
   } request_type;

   typedef struct packed {
      logic [cte_pkg::KIND_W-1:0]   kind;
      logic [cte_pkg::CODE_W-1:0]   code;
      logic [cte_pkg::LENGTH_W-1:0] length;
      logic [cte_pkg::SYMBOL_W-1:0] symbol;
   } response_type;

   // one line of the directed table: either an entry_count write or a
   // transaction repeated reps times; a typed response applies to the last
   // repetition only, the earlier ones must stay silent
   typedef struct packed {
      bit                          is_cfg;
      logic [cte_pkg::COUNT_W-1:0] cfg_value;
      request_type                 rq;
      int                          reps;
      bit                          typed;
      bit                          typed_has;
      response_type                typed_rs;
   } row_type;

   localparam response_type NO_RSP = '0;
   localparam request_type  NO_REQ = '0;

   logic                         clock;
   logic                         reset;
   logic                         start;
   logic                         busy;
   logic [cte_pkg::KIND_W-1:0]   req_kind;
   logic [cte_pkg::INDEX_W-1:0]  req_entry_index;
   logic [cte_pkg::SYMBOL_W-1:0] req_symbol;
   logic [cte_pkg::CODE_W-1:0]   req_code_bits;
   logic [cte_pkg::LENGTH_W-1:0] req_code_length;
   logic                         req_data_bit;
   logic                         rsp_strobe;
   logic [cte_pkg::KIND_W-1:0]   rsp_result_kind;
   logic [cte_pkg::CODE_W-1:0]   rsp_code_out;
   logic [cte_pkg::LENGTH_W-1:0] rsp_code_out_length;
   logic [cte_pkg::SYMBOL_W-1:0] rsp_symbol_out;
   logic                         csr_we;
   logic [cte_pkg::COUNT_W-1:0]  csr_wdata;

   // shadow of the block: table, bit accumulator and entry count
   cte_pkg::entry_type           table_copy [ENTRIES];
   logic [63:0]                  held_bits = '0;
   int                           held_bit_count = 0;
   logic [cte_pkg::COUNT_W-1:0]  entry_count_reg = '0;

   // stimulus bookkeeping: entries written so far, so no scan ever reads
   // an entry that was never loaded
   bit                           loaded [ENTRIES];
   bit                           decode_bits_q [$];
   response_type                 awaited_responses [$];
   response_type                 oldest;
   row_type                      rows [$];
   int                           phase_counts [PHASES];
   int                           error_count = 0;

   code_table_encode_decode i_dut (
      .clock               (clock),
      .reset               (reset),
      .start               (start),
      .busy                (busy),
      .req_kind            (req_kind),
      .req_entry_index     (req_entry_index),
      .req_symbol          (req_symbol),
      .req_code_bits       (req_code_bits),
      .req_code_length     (req_code_length),
      .req_data_bit        (req_data_bit),
      .rsp_strobe          (rsp_strobe),
      .rsp_result_kind     (rsp_result_kind),
      .rsp_code_out        (rsp_code_out),
      .rsp_code_out_length (rsp_code_out_length),
      .rsp_symbol_out      (rsp_symbol_out),
      .csr_we              (csr_we),
      .csr_wdata           (csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   // hard stop in case the block hangs; far beyond the slowest legal run
   initial begin
      #15ms;
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

   task automatic report_error(input string what);
      error_count++;
      // keep the log bounded when something goes badly wrong
      if (error_count <= PRINT_LIMIT) begin
         $display("%0t ERROR: %s", $time, what);
      end
   endtask

   // Applies one accepted transaction to the shadow state and works out the
   // response the block owes for it, if any.
   function automatic void table_response(input request_type rq, output bit has,
                                          output response_type rs);
      int          searched;
      logic [31:0] masked;
      has = 1'b0;
      rs = NO_RSP;
      searched = (entry_count_reg > ENTRIES) ? ENTRIES : int'(entry_count_reg);
      case (rq.kind)
         cte_pkg::KIND_LOAD: begin
            // code bits beyond the length are dropped; odd lengths kept as is
            masked = rq.bits;
            if (rq.length < 32) begin
               masked = masked & ((32'h1 << rq.length) - 32'h1);
            end
            table_copy[rq.index] = '{sym: rq.symbol, bits: masked, len: rq.length};
         end
         cte_pkg::KIND_ENCODE: begin
            // lowest-index entry holding the symbol wins
            for (int i = 0; i < searched && !has; i++) begin
               if (table_copy[i].sym == rq.symbol) begin
                  has = 1'b1;
                  rs = '{cte_pkg::RES_CODE, table_copy[i].bits, table_copy[i].len,
                         8'h00};
               end
            end
         end
         cte_pkg::KIND_DECODE: begin
            held_bits = {held_bits[62:0], rq.data_bit};
            held_bit_count++;
            for (int i = 0; i < searched && !has; i++) begin
               if (table_copy[i].len == held_bit_count &&
                   {32'h0, table_copy[i].bits} == held_bits) begin
                  has = 1'b1;
                  rs = '{cte_pkg::RES_SYMBOL, 32'h0, 6'h0, table_copy[i].sym};
               end
            end
            // a match at the last allowed bit beats the overflow
            if (!has && held_bit_count >= MAX_LEN) begin
               has = 1'b1;
               rs = '{cte_pkg::RES_OVERFLOW, 32'h0, 6'h0, 8'h00};
            end
            if (has) begin
               held_bits = '0;
               held_bit_count = 0;
            end
         end
         default: begin
         end
      endcase
   endfunction

   function automatic request_type mk_req(input logic [cte_pkg::KIND_W-1:0] kind,
                                          input int idx, input int sym,
                                          input logic [31:0] bits,
                                          input int len, input int dbit);
      mk_req = '{kind, idx[7:0], sym[7:0], bits, len[5:0], dbit[0]};
   endfunction

   function automatic response_type mk_rsp(input logic [cte_pkg::KIND_W-1:0] kind,
                                           input logic [31:0] code, input int len,
                                           input int sym);
      mk_rsp = '{kind, code, len[5:0], sym[7:0]};
   endfunction

   // every field random; callers then fix the fields that matter
   function automatic request_type random_fields();
      request_type rq;
      rq.kind     = cte_pkg::KIND_W'($urandom_range(3));
      rq.index    = cte_pkg::INDEX_W'($urandom_range(255));
      rq.symbol   = cte_pkg::SYMBOL_W'($urandom_range(255));
      rq.bits     = $urandom();
      rq.length   = cte_pkg::LENGTH_W'($urandom_range(63));
      rq.data_bit = 1'($urandom_range(1));
      return rq;
   endfunction

   // mostly lengths from the phase's range, some full-range, a few odd ones
   // (zero or beyond the longest code) that encode but never decode
   function automatic int pick_length(input int lo, input int hi);
      int r;
      r = $urandom_range(99);
      if (r < 3) begin
         return $urandom_range(1) ? 0 : $urandom_range(63, MAX_LEN + 1);
      end else if (r < 13) begin
         return $urandom_range(MAX_LEN, 1);
      end
      return $urandom_range(hi, lo);
   endfunction

   // Drive one transaction at the falling edge and hold it until an edge
   // with busy low takes it. start is left high so a back-to-back
   // transaction needs no second assignment in the same time step.
   task automatic send_request(input request_type rq, input bit typed, input bit typed_has,
                               input response_type typed_rs);
      bit           has;
      response_type rs;
      @(negedge clock);
      start           <= 1'b1;
      req_kind        <= rq.kind;
      req_entry_index <= rq.index;
      req_symbol      <= rq.symbol;
      req_code_bits   <= rq.bits;
      req_code_length <= rq.length;
      req_data_bit    <= rq.data_bit;
      @(posedge clock);
      while (busy !== 1'b0) @(posedge clock);
      table_response(rq, has, rs);
      if (typed) begin
         has = typed_has;
         rs = typed_rs;
      end
      if (has) begin
         awaited_responses.push_back(rs);
      end
      if (rq.kind == cte_pkg::KIND_LOAD) begin
         loaded[rq.index] = 1'b1;
      end
   endtask

   // random gap after a transaction: mostly none or short, a few long
   task automatic idle_after_item(input bit quiet);
      int r;
      int gap;
      r = $urandom_range(99);
      if (quiet || r < 55) begin
         gap = 0;
      end else if (r < 85) begin
         gap = $urandom_range(3, 1);
      end else if (r < 97) begin
         gap = $urandom_range(12, 4);
      end else begin
         gap = $urandom_range(150, 20);
      end
      if (gap > 0) begin
         @(negedge clock);
         start <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   // sender holds off until every owed response is in (bounded)
   task automatic wait_for_responses();
      int guard;
      @(negedge clock);
      start <= 1'b0;
      for (guard = 0; guard < WAIT_LIMIT && awaited_responses.size() != 0; guard++) begin
         @(posedge clock);
      end
   endtask

   // register writes only with the block idle: no response owed and any
   // silent transaction given time to finish
   task automatic set_entry_count(input logic [cte_pkg::COUNT_W-1:0] value);
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      @(negedge clock);
      csr_we    <= 1'b1;
      csr_wdata <= value;
      @(negedge clock);
      csr_we    <= 1'b0;
      entry_count_reg = value;
   endtask

   // Scoreboard: every strobed response is matched against the oldest
   // outstanding prediction, field by field.
   always @(posedge clock) begin
      if (reset === 1'b0 && rsp_strobe === 1'b1) begin
         if (awaited_responses.size() == 0) begin
            report_error($sformatf("response with nothing pending: kind %0d symbol %0h",
                                   rsp_result_kind, rsp_symbol_out));
         end else begin
            oldest = awaited_responses.pop_front();
            if (rsp_result_kind !== oldest.kind) begin
               report_error($sformatf("result kind %0d, wanted %0d",
                                      rsp_result_kind, oldest.kind));
            end
            if (rsp_code_out !== oldest.code) begin
               report_error($sformatf("code %0h, wanted %0h", rsp_code_out, oldest.code));
            end
            if (rsp_code_out_length !== oldest.length) begin
               report_error($sformatf("code length %0d, wanted %0d",
                                      rsp_code_out_length, oldest.length));
            end
            if (rsp_symbol_out !== oldest.symbol) begin
               report_error($sformatf("symbol %0h, wanted %0h",
                                      rsp_symbol_out, oldest.symbol));
            end
         end
      end
   end

   initial begin
      request_type rq;
      row_type     row;
      int          searched;
      int          len_lo;
      int          len_hi;
      int          target;
      int          issued;
      int          r;
      int          pick;
      bit          quiet;
      bit          found;

      reset           = 1'b1;
      start           = 1'b0;
      req_kind        = cte_pkg::KIND_LOAD;
      req_entry_index = '0;
      req_symbol      = '0;
      req_code_bits   = '0;
      req_code_length = '0;
      req_data_bit    = 1'b0;
      csr_we          = 1'b0;
      csr_wdata       = '0;
      foreach (table_copy[i]) table_copy[i] = '0;
      foreach (loaded[i]) loaded[i] = 1'b0;

      // --- directed table -------------------------------------------------
      // entry_count is zero out of reset: nothing is searched
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_ENCODE, 0, 0, 0, 0, 0),
                       1, 1'b1, 1'b0, NO_RSP});
      // empty search: 32 ones gather and overflow
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_DECODE, 0, 0, 0, 0, 1),
                       MAX_LEN, 1'b1, 1'b1, mk_rsp(cte_pkg::RES_OVERFLOW, 0, 0, 0)});
      // unused kind with every field at its top value: dropped
      rows.push_back('{1'b0, 9'd0,
                       mk_req(KIND_UNUSED, 255, 255, 32'hFFFF_FFFF, 63, 1),
                       1, 1'b1, 1'b0, NO_RSP});
      // table: longest code, 1-bit code with high bits dropped, zero length,
      // length past the maximum, duplicate symbol at a higher index, 2-bit code
      rows.push_back('{1'b0, 9'd0,
                       mk_req(cte_pkg::KIND_LOAD, 0, 'hFF, 32'hFFFF_FFFF, 32, 0),
                       1, 1'b1, 1'b0, NO_RSP});
      rows.push_back('{1'b0, 9'd0,
                       mk_req(cte_pkg::KIND_LOAD, 1, 'h00, 32'hFFFF_FFFF, 1, 0),
                       1, 1'b1, 1'b0, NO_RSP});
      rows.push_back('{1'b0, 9'd0,
                       mk_req(cte_pkg::KIND_LOAD, 2, 'hA5, 32'hFFFF_FFFF, 0, 0),
                       1, 1'b1, 1'b0, NO_RSP});
      rows.push_back('{1'b0, 9'd0,
                       mk_req(cte_pkg::KIND_LOAD, 3, 'h5A, 32'hFFFF_FFFF, 63, 0),
                       1, 1'b1, 1'b0, NO_RSP});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_LOAD, 4, 'hFF, 32'h0, 1, 0),
                       1, 1'b1, 1'b0, NO_RSP});
      rows.push_back('{1'b0, 9'd0,
                       mk_req(cte_pkg::KIND_LOAD, 5, 'h3C, 32'hFFFF_FFFE, 2, 0),
                       1, 1'b1, 1'b0, NO_RSP});
      rows.push_back('{1'b1, 9'd6, NO_REQ, 0, 1'b0, 1'b0, NO_RSP});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_ENCODE, 0, 'hFF, 0, 0, 0),
                       1, 1'b1, 1'b1, mk_rsp(cte_pkg::RES_CODE, 32'hFFFF_FFFF, 32, 0)});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_ENCODE, 0, 'h00, 0, 0, 0),
                       1, 1'b1, 1'b1, mk_rsp(cte_pkg::RES_CODE, 32'h1, 1, 0)});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_ENCODE, 0, 'hA5, 0, 0, 0),
                       1, 1'b1, 1'b1, mk_rsp(cte_pkg::RES_CODE, 32'h0, 0, 0)});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_ENCODE, 0, 'h5A, 0, 0, 0),
                       1, 1'b1, 1'b1, mk_rsp(cte_pkg::RES_CODE, 32'hFFFF_FFFF, 63, 0)});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_ENCODE, 0, 'h3C, 0, 0, 0),
                       1, 1'b0, 1'b0, NO_RSP});
      // symbol not in the table: silent
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_ENCODE, 0, 'h77, 0, 0, 0),
                       1, 1'b1, 1'b0, NO_RSP});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_DECODE, 0, 0, 0, 0, 0),
                       1, 1'b1, 1'b1, mk_rsp(cte_pkg::RES_SYMBOL, 0, 0, 'hFF)});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_DECODE, 0, 0, 0, 0, 1),
                       1, 1'b1, 1'b1, mk_rsp(cte_pkg::RES_SYMBOL, 0, 0, 'h00)});
      // only entry 0 left: its 32-bit code matches on the very last bit
      rows.push_back('{1'b1, 9'd1, NO_REQ, 0, 1'b0, 1'b0, NO_RSP});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_DECODE, 0, 0, 0, 0, 1),
                       MAX_LEN, 1'b1, 1'b1, mk_rsp(cte_pkg::RES_SYMBOL, 0, 0, 'hFF)});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_DECODE, 0, 0, 0, 0, 0),
                       MAX_LEN, 1'b1, 1'b1, mk_rsp(cte_pkg::RES_OVERFLOW, 0, 0, 0)});
      rows.push_back('{1'b1, 9'd0, NO_REQ, 0, 1'b0, 1'b0, NO_RSP});
      rows.push_back('{1'b0, 9'd0, mk_req(cte_pkg::KIND_ENCODE, 0, 'hFF, 0, 0, 0),
                       1, 1'b1, 1'b0, NO_RSP});

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      foreach (rows[k]) begin
         row = rows[k];
         if (row.is_cfg) begin
            set_entry_count(row.cfg_value);
         end else begin
            for (int j = 0; j < row.reps; j++) begin
               send_request(row.rq, row.typed, row.typed_has && (j == row.reps - 1),
                            row.typed_rs);
               idle_after_item(1'b0);
            end
         end
      end

      // --- random phases --------------------------------------------------
      // Small counts carry most of the traffic since each scan may read every
      // searched entry; full-table and over-range counts get a short run.
      phase_counts = '{2, 1, 9, 16, 256, 511, 0, 0, 0, 0, 4};
      phase_counts[7] = $urandom_range(40, 3);
      phase_counts[8] = $urandom_range(510, 257);
      phase_counts[9] = $urandom_range(24, 3);

      for (int p = 0; p < PHASES; p++) begin
         searched = (phase_counts[p] > ENTRIES) ? ENTRIES : phase_counts[p];
         // long codes in big tables so short prefixes don't swallow all input
         len_lo = (searched > 16) ? 5 : 1;
         len_hi = (searched > 16) ? 24 : 8;

         // every searched entry gets written before the count exposes it
         for (int e = 0; e < searched; e++) begin
            if (!loaded[e]) begin
               rq = random_fields();
               rq.kind = cte_pkg::KIND_LOAD;
               rq.index = cte_pkg::INDEX_W'(e);
               rq.length = cte_pkg::LENGTH_W'(pick_length(len_lo, len_hi));
               if ($urandom_range(9) < 3) rq.symbol = cte_pkg::SYMBOL_W'($urandom_range(7));
               send_request(rq, 1'b0, 1'b0, NO_RSP);
               idle_after_item(1'b0);
            end
         end
         set_entry_count(cte_pkg::COUNT_W'(phase_counts[p]));

         target = (searched > 40) ? 60 : 200;
         issued = 0;
         quiet = 1'b0;
         while (issued < target || decode_bits_q.size() != 0) begin
            // stretches with no idling at all
            if (issued % 50 == 0) quiet = ($urandom_range(9) < 3);
            rq = random_fields();
            if (decode_bits_q.size() != 0) begin
               rq.kind = cte_pkg::KIND_DECODE;
               rq.data_bit = decode_bits_q.pop_front();
            end else begin
               r = $urandom_range(99);
               if (r < 12) begin
                  rq.kind = cte_pkg::KIND_LOAD;
                  if (searched > 0 && $urandom_range(9) < 7) begin
                     rq.index = cte_pkg::INDEX_W'($urandom_range(searched - 1));
                  end
                  rq.length = cte_pkg::LENGTH_W'(pick_length(len_lo, len_hi));
                  if ($urandom_range(9) < 3) begin
                     rq.symbol = cte_pkg::SYMBOL_W'($urandom_range(7));
                  end
               end else if (r < 45) begin
                  rq.kind = cte_pkg::KIND_ENCODE;
                  if (searched > 0 && $urandom_range(3) != 0) begin
                     rq.symbol =
                        table_copy[cte_pkg::INDEX_W'($urandom_range(searched - 1))].sym;
                  end
               end else if (r < 94) begin
                  // mostly a whole stored code sent MSB first from an empty
                  // accumulator; otherwise stray bits, which may run on to overflow
                  rq.kind = cte_pkg::KIND_DECODE;
                  if (held_bit_count == 0 && searched > 0 && $urandom_range(99) >= 12) begin
                     found = 1'b0;
                     for (int t = 0; t < 4 && !found; t++) begin
                        pick = $urandom_range(searched - 1);
                        if (table_copy[pick].len >= 1 && table_copy[pick].len <= MAX_LEN) begin
                           found = 1'b1;
                           for (int b = table_copy[pick].len - 1; b >= 0; b--) begin
                              decode_bits_q.push_back(table_copy[pick].bits[b]);
                           end
                        end
                     end
                     if (found) rq.data_bit = decode_bits_q.pop_front();
                  end
               end else begin
                  rq.kind = KIND_UNUSED;
               end
            end
            send_request(rq, 1'b0, 1'b0, NO_RSP);
            issued++;
            if ($urandom_range(99) < 2) begin
               wait_for_responses();
            end else begin
               idle_after_item(quiet);
            end
         end
      end

      // --- wind down ------------------------------------------------------
      wait_for_responses();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (awaited_responses.size() != 0) begin
         report_error($sformatf("%0d responses never arrived", awaited_responses.size()));
      end
      if (error_count == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

endmodule
